[hw/rtl/gtti_pkg.sv]
`timescale 1ns / 1ps

package gtti_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);

   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 6;
   localparam int POS_W    = 17;
   localparam int VAL_W    = 16;
   localparam int PHASE_W  = 16;
   localparam int CYC_W    = 8;
   localparam int RAMP_W   = 16;
   localparam int CLAMP_W  = 10;
   localparam int GAIN_W   = 32;
   localparam int TCOUNT_W = 7;
   localparam int TORQUE_W = 11;
   localparam int ENTRY_W  = POS_W + VAL_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 34;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   localparam int CLAMP_MAX = 1000;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD    = 2'd0,
      ACT_TICK    = 2'd1,
      ACT_RESTART = 2'd2
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PHASE_STEP       = 3'd0,
      REG_TOTAL_CYCLES     = 3'd1,
      REG_RAMP_TICKS       = 3'd2,
      REG_CLAMP_PERMILLE   = 3'd3,
      REG_TORQUE_GAIN      = 3'd4,
      REG_INVERT_DIRECTION = 3'd5,
      REG_TABLE_COUNT      = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [PHASE_W-1:0]       phase_step;
      logic [CYC_W-1:0]         total_cycles;
      logic [RAMP_W-1:0]        ramp_ticks;
      logic [CLAMP_W-1:0]       clamp_permille;
      logic signed [GAIN_W-1:0] torque_gain;
      logic                     invert_direction;
      logic [TCOUNT_W-1:0]      table_count;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      phase_step:       16'd98,
      total_cycles:     8'd5,
      ramp_ticks:       16'd0,
      clamp_permille:   10'd600,
      torque_gain:      32'sd1124,
      invert_direction: 1'b1,
      table_count:      7'd2
   };

   typedef struct packed {
      logic [POS_W-1:0]        pos;
      logic signed [VAL_W-1:0] val;
   } entry_type;

   typedef struct packed {
      logic signed [TORQUE_W-1:0] torque_permille;
      logic [PHASE_W-1:0]         gait_position;
      logic                       was_clamped;
      logic                       run_done;
   } rsp_type;

   typedef enum logic [1:0] {
      ADDR_HOLD = 2'd0,
      ADDR_ZERO = 2'd1,
      ADDR_LAST = 2'd2,
      ADDR_INC  = 2'd3
   } addr_op_type;

   typedef enum logic [2:0] {
      V_HOLD   = 3'd0,
      V_ZERO   = 3'd1,
      V_RDATA  = 3'd2,
      V_PREV   = 3'd3,
      V_INTERP = 3'd4
   } v_sel_type;

   typedef enum logic [1:0] {
      MUL_NONE   = 2'd0,
      MUL_INTERP = 2'd1,
      MUL_GAIN   = 2'd2,
      MUL_RAMP   = 2'd3
   } mul_sel_type;

   typedef enum logic [1:0] {
      DIV_NONE   = 2'd0,
      DIV_INTERP = 2'd1,
      DIV_RAMP   = 2'd2
   } div_sel_type;

   typedef struct packed {
      logic        wr_entry;
      logic        restart;
      logic        tick_start;
      addr_op_type addr_op;
      logic        take_prev;
      logic        capture_pair;
      v_sel_type   v_sel;
      mul_sel_type mul_sel;
      div_sel_type div_sel;
      logic        round_gain;
      logic        finish;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic run_over;
      logic n_zero;
      logic le_first;
      logic ge_last;
      logic bracket;
      logic equal;
      logic scan_last;
      logic div_done;
      logic out_busy;
   } status_type;

endpackage

[hw/rtl/gtti_if.sv]
`timescale 1ns / 1ps

interface gtti_req_if;
   import gtti_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [ACTION_W-1:0]     action;
   logic [INDEX_W-1:0]      entry_index;
   logic [POS_W-1:0]        entry_position;
   logic signed [VAL_W-1:0] entry_value;

   modport source (output valid, action, entry_index, entry_position, entry_value,
                   input ready);
   modport sink (input valid, action, entry_index, entry_position, entry_value,
                 output ready);
endinterface

interface gtti_rsp_if;
   import gtti_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [TORQUE_W-1:0] torque_permille;
   logic [PHASE_W-1:0]         gait_position;
   logic                       was_clamped;
   logic                       run_done;

   modport source (output valid, torque_permille, gait_position, was_clamped, run_done,
                   input ready);
   modport sink (input valid, torque_permille, gait_position, was_clamped, run_done,
                 output ready);
endinterface

[hw/rtl/gtti_ram.sv]
`timescale 1ns / 1ps

module gtti_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[hw/rtl/gtti_divider.sv]
`timescale 1ns / 1ps

module gtti_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [gtti_pkg::DIV_NUM_W-1:0] numer,
   input  logic [gtti_pkg::DIV_DEN_W-1:0] denom,
   output logic                           done,
   output logic [gtti_pkg::DIV_NUM_W-1:0] quotient
);
   import gtti_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;

   // restoring division, one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = denom;
         quo_in  = numer;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

[hw/rtl/gtti_datapath.sv]
`timescale 1ns / 1ps

module gtti_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  gtti_pkg::cfg_type                 cfg,
   input  gtti_pkg::cmd_type                 cmd,
   output gtti_pkg::status_type              status,
   input  logic [gtti_pkg::INDEX_W-1:0]      entry_index,
   input  logic [gtti_pkg::POS_W-1:0]        entry_position,
   input  logic signed [gtti_pkg::VAL_W-1:0] entry_value,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output gtti_pkg::rsp_type                 rsp_data
);
   import gtti_pkg::*;

   // run state
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [CYC_W-1:0]   cycles_ff, cycles_in;
   logic [RAMP_W-1:0]  ramp_ff, ramp_in;
   logic               finished_ff, finished_in;
   logic               done_ff, done_in;

   // table walk
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [POS_W-1:0]        prev_pos_ff, prev_pos_in;
   logic signed [VAL_W-1:0] prev_val_ff, prev_val_in;
   logic [POS_W-1:0]        diff_ff, diff_in;
   logic [POS_W-1:0]        span_ff, span_in;
   logic [VAL_W-1:0]        dv_mag_ff, dv_mag_in;
   logic                    dv_neg_ff, dv_neg_in;
   logic signed [VAL_W-1:0] va_ff, va_in;

   // arithmetic
   logic signed [31:0] v_ff, v_in;
   logic [63:0]        mul_ff, mul_in;
   logic [46:0]        pq_mag_ff, pq_mag_in;
   logic               sign_ff, sign_in;
   logic signed [TORQUE_W-1:0] res_torque_ff, res_torque_in;
   logic                       res_clamp_ff, res_clamp_in;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [ENTRY_W-1:0]  ram_rd_data;
   entry_type           rd_entry;
   logic                ram_wr_en;
   logic [TCOUNT_W-1:0] n_used;
   logic [POS_W-1:0]    p17;

   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_numer;
   logic [DIV_DEN_W-1:0] div_denom;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_quo;

   logic signed [VAL_W:0] dv;
   logic signed [31:0]    va_q16;
   logic signed [34:0]    interp_base;
   logic signed [34:0]    q35;
   logic signed [34:0]    interp_sum;
   logic [31:0]           v_mag;
   logic [31:0]           g_mag;
   logic [32:0]           imul;
   logic [63:0]           gmul;
   logic [62:0]           rmul;
   logic [63:0]           gain_sum;
   logic                  ramp_act;
   logic [RAMP_W-1:0]     e_sel;
   logic [RAMP_W-1:0]     r_sel;
   logic [CLAMP_W-1:0]    lim;
   logic                  clamp_hit;
   logic [CLAMP_W-1:0]    tm;
   logic [TORQUE_W-1:0]   tm11;
   logic [PHASE_W:0]      phase_sum;

   assign ram_wr_en = cmd.wr_entry && (int'(entry_index) < TABLE_DEPTH);

   gtti_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ADDR_W'(entry_index)),
      .wr_data({entry_position, entry_value}),
      .rd_addr(addr_ff),
      .rd_data(ram_rd_data)
   );

   gtti_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .numer   (div_numer),
      .denom   (div_denom),
      .done    (div_done),
      .quotient(div_quo)
   );

   assign rd_entry = entry_type'(ram_rd_data);
   assign p17      = {1'b0, phase_ff};
   assign n_used   = (int'(cfg.table_count) > TABLE_DEPTH) ? TCOUNT_W'(TABLE_DEPTH)
                                                           : cfg.table_count;

   assign status.run_over  = finished_ff || (cycles_ff >= cfg.total_cycles);
   assign status.n_zero    = (n_used == '0);
   assign status.le_first  = (p17 <= rd_entry.pos);
   assign status.ge_last   = (p17 >= rd_entry.pos);
   assign status.bracket   = (p17 >= prev_pos_ff) && (p17 <= rd_entry.pos);
   assign status.equal     = (prev_pos_ff == rd_entry.pos);
   // during the scan, read data belongs to the address before addr_ff
   assign status.scan_last = ((addr_ff - ADDR_W'(1)) == ADDR_W'(n_used - TCOUNT_W'(1)));
   assign status.div_done  = div_done;
   assign status.out_busy  = rsp_valid_ff && !rsp_ready;

   assign dv          = VAL_W'(0) + (17'(rd_entry.val) - 17'(prev_val_ff));
   assign va_q16      = {va_ff, 16'h0};
   assign interp_base = 35'(va_q16);
   assign q35         = signed'({1'b0, div_quo[33:0]});
   assign interp_sum  = interp_base + (dv_neg_ff ? -q35 : q35);

   assign v_mag = v_ff[31] ? (32'd0 - v_ff) : v_ff;
   assign g_mag = cfg.torque_gain[GAIN_W-1] ? (32'd0 - cfg.torque_gain) : cfg.torque_gain;
   assign imul  = diff_ff * dv_mag_ff;
   assign gmul  = v_mag * g_mag;
   assign rmul  = pq_mag_ff * e_sel;

   assign gain_sum = mul_ff + 64'd32768;

   assign ramp_act = (cfg.ramp_ticks != '0) && (ramp_ff < cfg.ramp_ticks);
   assign e_sel    = ramp_act ? ramp_ff : RAMP_W'(1);
   assign r_sel    = ramp_act ? cfg.ramp_ticks : RAMP_W'(1);

   assign lim       = (int'(cfg.clamp_permille) > CLAMP_MAX) ? CLAMP_W'(CLAMP_MAX)
                                                             : cfg.clamp_permille;
   assign clamp_hit = div_quo > 64'(lim);
   assign tm        = clamp_hit ? lim : div_quo[CLAMP_W-1:0];
   assign tm11      = TORQUE_W'(tm);

   assign phase_sum = {1'b0, phase_ff} + {1'b0, cfg.phase_step};

   // divider operands: n/d rounded half away is (2n + d) / 2d on magnitudes
   always_comb begin
      div_start = 1'b0;
      div_numer = '0;
      div_denom = '0;
      case (cmd.div_sel)
         DIV_INTERP: begin
            div_start = 1'b1;
            div_numer = 64'({mul_ff[32:0], 17'h0}) + 64'(span_ff);
            div_denom = DIV_DEN_W'({span_ff, 1'b0});
         end
         DIV_RAMP: begin
            div_start = 1'b1;
            div_numer = {mul_ff[62:0], 1'b0} + 64'({r_sel, 16'h0});
            div_denom = DIV_DEN_W'({r_sel, 17'h0});
         end
         default: ;
      endcase
   end

   always_comb begin
      phase_in      = phase_ff;
      cycles_in     = cycles_ff;
      ramp_in       = ramp_ff;
      finished_in   = finished_ff;
      done_in       = done_ff;
      addr_in       = addr_ff;
      prev_pos_in   = prev_pos_ff;
      prev_val_in   = prev_val_ff;
      diff_in       = diff_ff;
      span_in       = span_ff;
      dv_mag_in     = dv_mag_ff;
      dv_neg_in     = dv_neg_ff;
      va_in         = va_ff;
      v_in          = v_ff;
      mul_in        = mul_ff;
      pq_mag_in     = pq_mag_ff;
      sign_in       = sign_ff;
      res_torque_in = res_torque_ff;
      res_clamp_in  = res_clamp_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (cmd.restart) begin
         phase_in    = '0;
         cycles_in   = '0;
         ramp_in     = '0;
         finished_in = 1'b0;
      end
      if (cmd.tick_start) begin
         done_in = status.run_over;
      end

      case (cmd.addr_op)
         ADDR_ZERO: addr_in = '0;
         ADDR_LAST: addr_in = ADDR_W'(n_used - TCOUNT_W'(1));
         ADDR_INC:  addr_in = addr_ff + ADDR_W'(1);
         default:   ;
      endcase

      if (cmd.take_prev) begin
         prev_pos_in = rd_entry.pos;
         prev_val_in = rd_entry.val;
      end
      if (cmd.capture_pair) begin
         diff_in   = p17 - prev_pos_ff;
         span_in   = rd_entry.pos - prev_pos_ff;
         dv_neg_in = dv[VAL_W];
         dv_mag_in = dv[VAL_W] ? VAL_W'(-dv) : dv[VAL_W-1:0];
         va_in     = prev_val_ff;
      end

      case (cmd.v_sel)
         V_ZERO:   v_in = '0;
         V_RDATA:  v_in = {rd_entry.val, 16'h0};
         V_PREV:   v_in = {prev_val_ff, 16'h0};
         V_INTERP: v_in = interp_sum[31:0];
         default:  ;
      endcase

      case (cmd.mul_sel)
         MUL_INTERP: mul_in = 64'(imul);
         MUL_GAIN:   mul_in = gmul;
         MUL_RAMP:   mul_in = 64'(rmul);
         default:    ;
      endcase

      if (cmd.round_gain) begin
         pq_mag_in = gain_sum[62:16];
         sign_in   = v_ff[31] ^ cfg.torque_gain[GAIN_W-1] ^ cfg.invert_direction;
      end

      if (cmd.finish) begin
         res_clamp_in  = clamp_hit;
         res_torque_in = sign_ff ? signed'(TORQUE_W'(0) - tm11) : signed'(tm11);
      end

      if (cmd.emit) begin
         rsp_valid_in         = 1'b1;
         rsp_in.gait_position = phase_ff;
         if (done_ff) begin
            rsp_in.torque_permille = '0;
            rsp_in.was_clamped     = 1'b0;
            rsp_in.run_done        = 1'b1;
            finished_in            = 1'b1;
         end else begin
            rsp_in.torque_permille = res_torque_ff;
            rsp_in.was_clamped     = res_clamp_ff;
            rsp_in.run_done        = 1'b0;
            phase_in               = phase_sum[PHASE_W-1:0];
            if (phase_sum[PHASE_W] && (cycles_ff != '1)) begin
               cycles_in = cycles_ff + CYC_W'(1);
            end
            if (ramp_ff != '1) begin
               ramp_in = ramp_ff + RAMP_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         cycles_ff    <= '0;
         ramp_ff      <= '0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         cycles_ff    <= cycles_in;
         ramp_ff      <= ramp_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      done_ff       <= done_in;
      addr_ff       <= addr_in;
      prev_pos_ff   <= prev_pos_in;
      prev_val_ff   <= prev_val_in;
      diff_ff       <= diff_in;
      span_ff       <= span_in;
      dv_mag_ff     <= dv_mag_in;
      dv_neg_ff     <= dv_neg_in;
      va_ff         <= va_in;
      v_ff          <= v_in;
      mul_ff        <= mul_in;
      pq_mag_ff     <= pq_mag_in;
      sign_ff       <= sign_in;
      res_torque_ff <= res_torque_in;
      res_clamp_ff  <= res_clamp_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

[hw/rtl/gtti_controller.sv]
`timescale 1ns / 1ps

module gtti_controller (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [gtti_pkg::ACTION_W-1:0] req_action,
   output logic                         req_ready,
   input  gtti_pkg::status_type         status,
   output gtti_pkg::cmd_type            cmd
);
   import gtti_pkg::*;

   typedef enum logic [16:0] {
      ST_IDLE   = 17'h00001,
      ST_RD0    = 17'h00002,
      ST_CHK0   = 17'h00004,
      ST_CHKL   = 17'h00008,
      ST_SCAN0  = 17'h00010,
      ST_SCAN   = 17'h00020,
      ST_I_MUL  = 17'h00040,
      ST_I_DIV  = 17'h00080,
      ST_I_WAIT = 17'h00100,
      ST_G_MUL  = 17'h00200,
      ST_G_RND  = 17'h00400,
      ST_R_MUL  = 17'h00800,
      ST_R_DIV  = 17'h01000,
      ST_R_WAIT = 17'h02000,
      ST_FIN    = 17'h04000,
      ST_OUT    = 17'h08000,
      ST_SPARE  = 17'h10000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (action_type'(req_action))
                  ACT_LOAD:    cmd.wr_entry = 1'b1;
                  ACT_RESTART: cmd.restart = 1'b1;
                  ACT_TICK: begin
                     cmd.tick_start = 1'b1;
                     cmd.addr_op    = ADDR_ZERO;
                     state_in       = status.run_over ? ST_OUT : ST_RD0;
                  end
                  default: ;
               endcase
            end
         end
         ST_RD0: begin
            if (status.n_zero) begin
               cmd.v_sel = V_ZERO;
               state_in  = ST_G_MUL;
            end else begin
               cmd.addr_op = ADDR_LAST;
               state_in    = ST_CHK0;
            end
         end
         ST_CHK0: begin
            // first entry on the read port
            if (status.le_first) begin
               cmd.v_sel = V_RDATA;
               state_in  = ST_G_MUL;
            end else begin
               cmd.addr_op = ADDR_ZERO;
               state_in    = ST_CHKL;
            end
         end
         ST_CHKL: begin
            // last used entry on the read port
            if (status.ge_last) begin
               cmd.v_sel = V_RDATA;
               state_in  = ST_G_MUL;
            end else begin
               cmd.addr_op = ADDR_INC;
               state_in    = ST_SCAN0;
            end
         end
         ST_SCAN0: begin
            cmd.take_prev = 1'b1;
            cmd.addr_op   = ADDR_INC;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.bracket) begin
               if (status.equal) begin
                  cmd.v_sel = V_PREV;
                  state_in  = ST_G_MUL;
               end else begin
                  cmd.capture_pair = 1'b1;
                  state_in         = ST_I_MUL;
               end
            end else if (status.scan_last) begin
               // no pair brackets the phase: last used value
               cmd.v_sel = V_RDATA;
               state_in  = ST_G_MUL;
            end else begin
               cmd.take_prev = 1'b1;
               cmd.addr_op   = ADDR_INC;
            end
         end
         ST_I_MUL: begin
            cmd.mul_sel = MUL_INTERP;
            state_in    = ST_I_DIV;
         end
         ST_I_DIV: begin
            cmd.div_sel = DIV_INTERP;
            state_in    = ST_I_WAIT;
         end
         ST_I_WAIT: begin
            if (status.div_done) begin
               cmd.v_sel = V_INTERP;
               state_in  = ST_G_MUL;
            end
         end
         ST_G_MUL: begin
            cmd.mul_sel = MUL_GAIN;
            state_in    = ST_G_RND;
         end
         ST_G_RND: begin
            cmd.round_gain = 1'b1;
            state_in       = ST_R_MUL;
         end
         ST_R_MUL: begin
            cmd.mul_sel = MUL_RAMP;
            state_in    = ST_R_DIV;
         end
         ST_R_DIV: begin
            cmd.div_sel = DIV_RAMP;
            state_in    = ST_R_WAIT;
         end
         ST_R_WAIT: begin
            if (status.div_done) begin
               cmd.finish = 1'b1;
               state_in   = ST_FIN;
            end
         end
         ST_FIN: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

[hw/rtl/gait_torque_table_interpolator.sv]
`timescale 1ns / 1ps
// Load, restart and unused actions: taken back to back, no result.
// Tick: the table scan (one entry per cycle, up to 63), the interpolation division (only
// when a pair is interpolated) and the ramp division run in turn before the result.
// A tick after the run is over skips the table and the divisions and gives a run_done result.
// Input ready again as the registered result turns valid; ticks do not overlap.
// Synchronous reset restores register defaults and clears run state; table is kept.
module gait_torque_table_interpolator (
   input  logic                              clock,
   input  logic                              reset,
   gtti_req_if.sink                          req_ch,
   gtti_rsp_if.source                        rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [gtti_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gtti_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import gtti_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;
   rsp_type    rsp_data;
   logic       rsp_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (reg_index_type'(csr_index))
            REG_PHASE_STEP:       cfg_in.phase_step = csr_wdata[PHASE_W-1:0];
            REG_TOTAL_CYCLES:     cfg_in.total_cycles = csr_wdata[CYC_W-1:0];
            REG_RAMP_TICKS:       cfg_in.ramp_ticks = csr_wdata[RAMP_W-1:0];
            REG_CLAMP_PERMILLE:   cfg_in.clamp_permille = csr_wdata[CLAMP_W-1:0];
            REG_TORQUE_GAIN:      cfg_in.torque_gain = csr_wdata[GAIN_W-1:0];
            REG_INVERT_DIRECTION: cfg_in.invert_direction = csr_wdata[0];
            REG_TABLE_COUNT:      cfg_in.table_count = csr_wdata[TCOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gtti_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_action(req_ch.action),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   gtti_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .cmd           (cmd),
      .status        (status),
      .entry_index   (req_ch.entry_index),
      .entry_position(req_ch.entry_position),
      .entry_value   (req_ch.entry_value),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data)
   );

   assign rsp_ch.valid           = rsp_valid;
   assign rsp_ch.torque_permille = rsp_data.torque_permille;
   assign rsp_ch.gait_position   = rsp_data.gait_position;
   assign rsp_ch.was_clamped     = rsp_data.was_clamped;
   assign rsp_ch.run_done        = rsp_data.run_done;
endmodule

[hw/rtl/gtti_checker.sv]
`timescale 1ns / 1ps

module gtti_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [gtti_pkg::TORQUE_W-1:0] torque_permille,
   input logic [gtti_pkg::PHASE_W-1:0]       gait_position,
   input logic                               was_clamped,
   input logic                               run_done
);
   // a stalled result transfer holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(torque_permille)
         && $stable(gait_position) && $stable(was_clamped) && $stable(run_done))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && run_done |-> torque_permille == 0 && !was_clamped)
      else $error("finished run gave nonzero torque");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> torque_permille <= 11'sd1000 && torque_permille >= -11'sd1000)
      else $error("torque outside limit");
endmodule

bind gait_torque_table_interpolator gtti_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .torque_permille(rsp_ch.torque_permille),
   .gait_position  (rsp_ch.gait_position),
   .was_clamped    (rsp_ch.was_clamped),
   .run_done       (rsp_ch.run_done)
);
